/* rtl/core/mfs_pkg.sv */
package mfs_pkg;

  localparam int MAX_USERS_DEF   = 1024;
  localparam int MAX_MOVIES_DEF  = 2048;
  localparam int FACTORS_DEF     = 20;
  localparam int VALUE_WIDTH_DEF = 16;

  // register indexes on the configuration port
  localparam logic [2:0] REG_USER_COUNT  = 3'd0;
  localparam logic [2:0] REG_MOVIE_COUNT = 3'd1;
  localparam logic [2:0] REG_LEARN_RATE  = 3'd2;
  localparam logic [2:0] REG_DECAY       = 3'd3;
  localparam logic [2:0] REG_GLOBAL_MEAN = 3'd4;

  localparam logic [10:0] USER_COUNT_RST  = 11'd1024;
  localparam logic [11:0] MOVIE_COUNT_RST = 12'd2048;
  localparam logic [15:0] LEARN_RATE_RST  = 16'd328;
  localparam logic [15:0] DECAY_RST       = 16'd655;
  localparam logic [14:0] GLOBAL_MEAN_RST = 15'd14459;

  localparam logic [1:0] ACT_TRAIN    = 2'd0;
  localparam logic [1:0] ACT_PREDICT  = 2'd1;
  localparam logic [1:0] ACT_WR_USER  = 2'd2;
  localparam logic [1:0] ACT_WR_MOVIE = 2'd3;

  typedef struct packed {
    logic [10:0] user_count;
    logic [11:0] movie_count;
    logic [15:0] learn_rate;
    logic [15:0] decay;
    logic [14:0] global_mean;
  } cfg_t;

  // one entry travelling through the update pipeline; bias marks the last slot
  typedef struct packed {
    logic valid;
    logic bias;
  } upd_ctl_t;

endpackage

/* rtl/core/mfs_ram.sv */
module mfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/mfs_regs.sv */
module mfs_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mfs_pkg::cfg_t cfg_o
);

  mfs_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.user_count  <= mfs_pkg::USER_COUNT_RST;
      cfg_q.movie_count <= mfs_pkg::MOVIE_COUNT_RST;
      cfg_q.learn_rate  <= mfs_pkg::LEARN_RATE_RST;
      cfg_q.decay       <= mfs_pkg::DECAY_RST;
      cfg_q.global_mean <= mfs_pkg::GLOBAL_MEAN_RST;
    end else if (wr) begin
      case (idx)
        mfs_pkg::REG_USER_COUNT:  cfg_q.user_count  <= pwdata[10:0];
        mfs_pkg::REG_MOVIE_COUNT: cfg_q.movie_count <= pwdata[11:0];
        mfs_pkg::REG_LEARN_RATE:  cfg_q.learn_rate  <= pwdata[15:0];
        mfs_pkg::REG_DECAY:       cfg_q.decay       <= pwdata[15:0];
        mfs_pkg::REG_GLOBAL_MEAN: cfg_q.global_mean <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mfs_pkg::REG_USER_COUNT:  prdata = {21'd0, cfg_q.user_count};
      mfs_pkg::REG_MOVIE_COUNT: prdata = {20'd0, cfg_q.movie_count};
      mfs_pkg::REG_LEARN_RATE:  prdata = {16'd0, cfg_q.learn_rate};
      mfs_pkg::REG_DECAY:       prdata = {16'd0, cfg_q.decay};
      mfs_pkg::REG_GLOBAL_MEAN: prdata = {17'd0, cfg_q.global_mean};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/mfs_upd.sv */
module mfs_upd #(
  parameter int VW = mfs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mfs_pkg::upd_ctl_t    ctl_i,
  input  logic signed [VW-1:0] self_i,
  input  logic signed [VW-1:0] other_i,
  input  logic signed [15:0]   err_i,
  input  logic [15:0]          learn_rate_i,
  input  logic [15:0]          decay_i,
  output mfs_pkg::upd_ctl_t    ctl_o,
  output logic signed [VW-1:0] new_o
);

  localparam int G_W  = (VW + 22 > 49) ? VW + 22 : 49;
  localparam int NV_W = ((VW > 34) ? VW : 34) + 1;
  localparam logic signed [G_W-1:0]  ILIM = G_W'(64'h0000_7FFF_FFFF_FFFF);
  localparam logic signed [NV_W-1:0] VMAX = (NV_W'(1) <<< (VW - 1)) - NV_W'(1);
  localparam logic signed [NV_W-1:0] VMIN = -VMAX - NV_W'(1);

  mfs_pkg::upd_ctl_t a_ctl_q, b_ctl_q, c_ctl_q, d_ctl_q;
  logic signed [VW+15:0] a_prod_q;
  logic signed [VW+16:0] a_dp_q;
  logic signed [VW-1:0]  a_old_q, b_old_q, c_old_q;
  logic signed [47:0]    b_inner_q;
  logic [39:0]           c_lo_q;
  logic signed [40:0]    c_hi_q;
  logic signed [VW-1:0]  d_new_q;

  logic signed [G_W-1:0]  grad, diff;
  logic signed [47:0]     inner_d;
  logic [65:0]            sum;
  logic signed [33:0]     delta;
  logic signed [NV_W-1:0] nv;
  logic signed [VW-1:0]   new_d;

  // gradient in Q.28: the error alone for a bias, error times the partner factor otherwise
  always_comb begin
    grad = a_ctl_q.bias ? (G_W'(err_i) <<< 16) : (G_W'(a_prod_q) <<< 4);
    diff = grad - G_W'(a_dp_q);
    if (diff > ILIM) begin
      inner_d = ILIM[47:0];
    end else if (diff < -ILIM) begin
      inner_d = -ILIM[47:0];
    end else begin
      inner_d = diff[47:0];
    end
  end

  // round half up of learn_rate * inner / 2^32, then saturate
  always_comb begin
    sum   = (66'(c_hi_q) << 24) + {26'd0, c_lo_q} + (66'd1 << 31);
    delta = $signed(sum[65:32]);
    nv    = NV_W'(c_old_q) + NV_W'(delta);
    if (nv > VMAX) begin
      new_d = VMAX[VW-1:0];
    end else if (nv < VMIN) begin
      new_d = VMIN[VW-1:0];
    end else begin
      new_d = nv[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
      b_ctl_q <= '0;
      c_ctl_q <= '0;
      d_ctl_q <= '0;
    end else begin
      a_ctl_q <= ctl_i;
      b_ctl_q <= a_ctl_q;
      c_ctl_q <= b_ctl_q;
      d_ctl_q <= c_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_prod_q  <= err_i * other_i;
    a_dp_q    <= $signed({1'b0, decay_i}) * self_i;
    a_old_q   <= self_i;
    b_inner_q <= inner_d;
    b_old_q   <= a_old_q;
    c_lo_q    <= learn_rate_i * b_inner_q[23:0];
    c_hi_q    <= $signed({1'b0, learn_rate_i}) * $signed(b_inner_q[47:24]);
    c_old_q   <= b_old_q;
    d_new_q   <= new_d;
  end

  assign ctl_o = d_ctl_q;
  assign new_o = d_new_q;

endmodule

/* rtl/core/biased_matrix_factorization_sgd.sv */
// Biased matrix factorization trained by SGD. User and movie rows (FACTORS
// factors plus one bias word each) live in two one-port-read RAMs. Assert
// start while busy is low to hand in one action; the result appears on the
// result ports for exactly one cycle with result_valid_o and cannot be held
// off. Write actions and rejected indices answer in the next cycle and leave
// busy low. Predict walks the row for the dot product (one RAM read per slot,
// the bias slot last) and then steps through PRED, ERR and SQ. Train returns
// its result at the same point and then stays busy while the update
// pipeline reads and writes back each factor pair and both biases. After
// reset the block is busy while the bias words of max(MAX_USERS, MAX_MOVIES)
// rows are cleared, one row per cycle; register writes are taken then.
module biased_matrix_factorization_sgd #(
  parameter int MAX_USERS   = mfs_pkg::MAX_USERS_DEF,
  parameter int MAX_MOVIES  = mfs_pkg::MAX_MOVIES_DEF,
  parameter int FACTORS     = mfs_pkg::FACTORS_DEF,
  parameter int VALUE_WIDTH = mfs_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic [9:0]         user_index_i,
  input  logic [10:0]        movie_index_i,
  input  logic [14:0]        rating_i,
  input  logic [4:0]         factor_slot_i,
  input  logic signed [15:0] factor_value_i,
  output logic               result_valid_o,
  output logic signed [15:0] predicted_rating_o,
  output logic signed [15:0] rating_error_o,
  output logic [31:0]        squared_error_o,
  output logic               out_of_range_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int VW     = VALUE_WIDTH;
  localparam int ROW    = FACTORS + 1;
  localparam int UDEPTH = MAX_USERS * ROW;
  localparam int MDEPTH = MAX_MOVIES * ROW;
  localparam int UAW    = $clog2(UDEPTH);
  localparam int MAW    = $clog2(MDEPTH);
  localparam int SW     = $clog2(ROW);
  localparam int MAXR   = (MAX_USERS > MAX_MOVIES) ? MAX_USERS : MAX_MOVIES;
  localparam int RW     = $clog2(MAXR + 1);
  localparam int PR_W   = 2 * VW;
  localparam int ACC_W  = 2 * VW + 8;
  localparam int B_W    = ((VW > 15) ? VW : 15) + 3;
  localparam int P_W    = ACC_W - 11;
  localparam int E_W    = P_W + 1;
  localparam logic [SW-1:0] LAST = SW'(FACTORS);
  localparam logic signed [63:0] PLIM = 64'sd1 <<< 56;
  localparam logic signed [32:0] VMAX33 = (33'sd1 <<< (VW - 1)) - 33'sd1;
  localparam logic signed [32:0] VMIN33 = -VMAX33 - 33'sd1;
  localparam logic signed [E_W-1:0] S16MAX = E_W'(32767);
  localparam logic signed [E_W-1:0] S16MIN = -S16MAX - E_W'(1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DOT  = 3'd2;
  localparam logic [2:0] ST_PRED = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;
  localparam logic [2:0] ST_SQ   = 3'd5;
  localparam logic [2:0] ST_UPD  = 3'd6;

  mfs_pkg::cfg_t     cfg;
  mfs_pkg::upd_ctl_t upd_in, upd_u_ctl, upd_m_ctl;

  logic [2:0]              state_q;
  logic [RW-1:0]           clr_q;
  logic [SW-1:0]           rk_q, rs_q, wk_q;
  logic                    iss_q, rv_q, pv_q;
  logic                    train_q;
  logic [14:0]             rating_q;
  logic [UAW-1:0]          base_u_q;
  logic [MAW-1:0]          base_m_q;
  logic signed [PR_W-1:0]  prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [VW-1:0]    bu_q, bm_q;
  logic signed [P_W-1:0]   pred_q;
  logic signed [15:0]      pred_out_q, err_q;
  logic [31:0]             sq_q;
  logic                    res_valid_q, oor_q;

  logic                    accept, issuing, user_ok, movie_ok, wr_ok;
  logic [31:0]             base_u_w, base_m_w, clr_u_w, clr_m_w;
  logic signed [32:0]      fv_w;
  logic signed [VW-1:0]    fv_sat;
  logic signed [63:0]      prod_w, prod_c;
  logic signed [B_W-1:0]   bsum;
  logic signed [ACC_W:0]   total;
  logic signed [E_W-1:0]   err_full, pred_ext;
  logic signed [31:0]      sq_w;

  logic                 u_we, m_we;
  logic [UAW-1:0]       u_waddr, u_raddr;
  logic [MAW-1:0]       m_waddr, m_raddr;
  logic signed [VW-1:0] u_wdata, m_wdata, u_rdata, m_rdata, u_new, m_new;

  mfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mfs_ram #(.WIDTH(VW), .DEPTH(UDEPTH)) u_user_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  mfs_ram #(.WIDTH(VW), .DEPTH(MDEPTH)) u_movie_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  assign upd_in.valid = rv_q && (state_q == ST_UPD);
  assign upd_in.bias  = (rs_q == LAST);

  // the movie side sees the old user factor, since both read the same snapshot
  mfs_upd #(.VW(VW)) u_upd_user (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (upd_in),
    .self_i       (u_rdata),
    .other_i      (m_rdata),
    .err_i        (err_q),
    .learn_rate_i (cfg.learn_rate),
    .decay_i      (cfg.decay),
    .ctl_o        (upd_u_ctl),
    .new_o        (u_new)
  );

  mfs_upd #(.VW(VW)) u_upd_movie (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (upd_in),
    .self_i       (m_rdata),
    .other_i      (u_rdata),
    .err_i        (err_q),
    .learn_rate_i (cfg.learn_rate),
    .decay_i      (cfg.decay),
    .ctl_o        (upd_m_ctl),
    .new_o        (m_new)
  );

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign issuing = iss_q && ((state_q == ST_DOT) || (state_q == ST_UPD));

  always_comb begin
    user_ok  = (32'(user_index_i) < 32'(cfg.user_count)) &&
               (32'(user_index_i) < MAX_USERS);
    movie_ok = (32'(movie_index_i) < 32'(cfg.movie_count)) &&
               (32'(movie_index_i) < MAX_MOVIES);
    wr_ok    = ((action_i == mfs_pkg::ACT_WR_USER) ? user_ok : movie_ok) &&
               (32'(factor_slot_i) < FACTORS);
    base_u_w = 32'(user_index_i) * 32'(ROW);
    base_m_w = 32'(movie_index_i) * 32'(ROW);
    clr_u_w  = 32'(clr_q) * 32'(ROW) + 32'(FACTORS);
    clr_m_w  = clr_u_w;
    fv_w     = 33'(factor_value_i);
    if (fv_w > VMAX33) begin
      fv_sat = VMAX33[VW-1:0];
    end else if (fv_w < VMIN33) begin
      fv_sat = VMIN33[VW-1:0];
    end else begin
      fv_sat = fv_w[VW-1:0];
    end
  end

  assign u_raddr = base_u_q + UAW'(rk_q);
  assign m_raddr = base_m_q + MAW'(rk_q);

  always_comb begin
    u_we    = 1'b0;
    u_waddr = base_u_q + UAW'(wk_q);
    u_wdata = u_new;
    m_we    = 1'b0;
    m_waddr = base_m_q + MAW'(wk_q);
    m_wdata = m_new;
    if (state_q == ST_CLR) begin
      u_we    = 32'(clr_q) < MAX_USERS;
      u_waddr = clr_u_w[UAW-1:0];
      u_wdata = '0;
      m_we    = 32'(clr_q) < MAX_MOVIES;
      m_waddr = clr_m_w[MAW-1:0];
      m_wdata = '0;
    end else if (accept && wr_ok && (action_i == mfs_pkg::ACT_WR_USER)) begin
      u_we    = 1'b1;
      u_waddr = base_u_w[UAW-1:0] + UAW'(factor_slot_i);
      u_wdata = fv_sat;
    end else if (accept && wr_ok && (action_i == mfs_pkg::ACT_WR_MOVIE)) begin
      m_we    = 1'b1;
      m_waddr = base_m_w[MAW-1:0] + MAW'(factor_slot_i);
      m_wdata = fv_sat;
    end else begin
      u_we = upd_u_ctl.valid;
      m_we = upd_m_ctl.valid;
    end
  end

  always_comb begin
    prod_w = 64'(u_rdata * m_rdata);
    if (prod_w > PLIM) begin
      prod_c = PLIM;
    end else if (prod_w < -PLIM) begin
      prod_c = -PLIM;
    end else begin
      prod_c = prod_w;
    end
    bsum     = B_W'($signed({1'b0, cfg.global_mean})) + B_W'(bu_q) + B_W'(bm_q);
    total    = (ACC_W + 1)'(acc_q) + ((ACC_W + 1)'(bsum) <<< 12) + (ACC_W + 1)'(2048);
    err_full = E_W'($signed({1'b0, rating_q})) - E_W'(pred_q);
    pred_ext = E_W'(pred_q);
    sq_w     = err_q * err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      rk_q        <= '0;
      wk_q        <= '0;
      iss_q       <= 1'b0;
      rv_q        <= 1'b0;
      pv_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      rv_q        <= issuing;
      pv_q        <= rv_q && (state_q == ST_DOT) && (rs_q != LAST);
      if (issuing) begin
        rk_q <= rk_q + SW'(1);
        if (rk_q == LAST) begin
          iss_q <= 1'b0;
        end
      end
      case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + RW'(1);
          if (clr_q == RW'(MAXR - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (action_i == mfs_pkg::ACT_WR_USER || action_i == mfs_pkg::ACT_WR_MOVIE ||
                !user_ok || !movie_ok) begin
              res_valid_q <= 1'b1;
            end else begin
              state_q <= ST_DOT;
              rk_q    <= '0;
              iss_q   <= 1'b1;
            end
          end
        end
        ST_DOT: begin
          // the bias slot comes last; the final product has been summed by then
          if (rv_q && rs_q == LAST) begin
            state_q <= ST_PRED;
          end
        end
        ST_PRED: state_q <= ST_ERR;
        ST_ERR:  state_q <= ST_SQ;
        ST_SQ: begin
          res_valid_q <= 1'b1;
          if (train_q) begin
            state_q <= ST_UPD;
            rk_q    <= '0;
            wk_q    <= '0;
            iss_q   <= 1'b1;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_UPD: begin
          if (upd_u_ctl.valid) begin
            wk_q <= wk_q + SW'(1);
            if (upd_u_ctl.bias) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q   <= rk_q;
    prod_q <= prod_c[PR_W-1:0];
    if (accept) begin
      train_q    <= (action_i == mfs_pkg::ACT_TRAIN);
      rating_q   <= rating_i;
      base_u_q   <= base_u_w[UAW-1:0];
      base_m_q   <= base_m_w[MAW-1:0];
      acc_q      <= '0;
      oor_q      <= (action_i == mfs_pkg::ACT_WR_USER || action_i == mfs_pkg::ACT_WR_MOVIE)
                    ? !wr_ok : !(user_ok && movie_ok);
      pred_out_q <= '0;
      err_q      <= '0;
      sq_q       <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (rv_q && state_q == ST_DOT && rs_q == LAST) begin
      bu_q <= u_rdata;
      bm_q <= m_rdata;
    end
    if (state_q == ST_PRED) begin
      pred_q <= total[ACC_W:12];
    end
    if (state_q == ST_ERR) begin
      if (err_full > S16MAX) begin
        err_q <= 16'sh7FFF;
      end else if (err_full < S16MIN) begin
        err_q <= 16'sh8000;
      end else begin
        err_q <= err_full[15:0];
      end
      if (pred_ext > S16MAX) begin
        pred_out_q <= 16'sh7FFF;
      end else if (pred_ext < S16MIN) begin
        pred_out_q <= 16'sh8000;
      end else begin
        pred_out_q <= pred_ext[15:0];
      end
    end
    if (state_q == ST_SQ) begin
      sq_q <= sq_w;
    end
  end

  assign result_valid_o     = res_valid_q;
  assign predicted_rating_o = pred_out_q;
  assign rating_error_o     = err_q;
  assign squared_error_o    = sq_q;
  assign out_of_range_o     = oor_q;

endmodule

/* tb/mfs_checker.sv */
module mfs_checker
  import mfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         action_i,
  input  logic [9:0]         user_index_i,
  input  logic [10:0]        movie_index_i,
  input  logic [14:0]        rating_i,
  input  logic [4:0]         factor_slot_i,
  input  logic signed [15:0] factor_value_i,
  input  logic               result_valid_o,
  input  logic signed [15:0] predicted_rating_o,
  input  logic signed [15:0] rating_error_o,
  input  logic [31:0]        squared_error_o,
  input  logic               out_of_range_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 pending_o,
  output int                 fails_o
);

  localparam int NF = FACTORS_DEF;
  localparam longint INNER_MAX = (longint'(1) << 47) - 1;
  localparam longint PROD_MAX = longint'(1) << 56;

  typedef struct packed {
    logic signed [15:0] pred;
    logic signed [15:0] err;
    logic [31:0]        sq;
    logic               oor;
  } rating_result_t;

  rating_result_t rating_results_q[$];

  int user_factor[MAX_USERS_DEF*NF];
  int movie_factor[MAX_MOVIES_DEF*NF];
  int user_bias[MAX_USERS_DEF];
  int movie_bias[MAX_MOVIES_DEF];

  logic [10:0] user_count_r  = USER_COUNT_RST;
  logic [11:0] movie_count_r = MOVIE_COUNT_RST;
  logic [15:0] learn_rate_r  = LEARN_RATE_RST;
  logic [15:0] decay_r       = DECAY_RST;
  logic [14:0] mean_r        = GLOBAL_MEAN_RST;

  initial begin
    pending_o = 0;
    fails_o = 0;
  end

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor((v + half) / 2^s)
  function automatic longint round_half_up(longint v, int s);
    longint one;
    one = 1;
    return (v + (one << (s - 1))) >>> s;
  endfunction

  function automatic int sgd_step(longint cur, longint grad28);
    longint inner;
    longint delta;
    inner = clamp_l(grad28 - longint'(decay_r) * cur, -INNER_MAX, INNER_MAX);
    delta = round_half_up(longint'(learn_rate_r) * inner, 32);
    return int'(clamp_l(cur + delta, -32768, 32767));
  endfunction

  task automatic predict_rating();
    rating_result_t r;
    int u, m, k;
    bit user_ok, movie_ok;
    longint dot, pred, err, p, q;
    r = '0;
    u = user_index_i;
    m = movie_index_i;
    user_ok = u < user_count_r;
    movie_ok = m < movie_count_r;
    if (action_i == ACT_WR_USER || action_i == ACT_WR_MOVIE) begin
      if (!((action_i == ACT_WR_USER ? user_ok : movie_ok) && factor_slot_i < NF)) begin
        r.oor = 1'b1;
      end else if (action_i == ACT_WR_USER) begin
        user_factor[u*NF + factor_slot_i] = int'(factor_value_i);
      end else begin
        movie_factor[m*NF + factor_slot_i] = int'(factor_value_i);
      end
    end else if (!user_ok || !movie_ok) begin
      r.oor = 1'b1;
    end else begin
      dot = 0;
      for (k = 0; k < NF; k++) begin
        dot += clamp_l(longint'(user_factor[u*NF+k]) * longint'(movie_factor[m*NF+k]),
                       -PROD_MAX, PROD_MAX);
      end
      pred = round_half_up(dot + (longint'(mean_r) + user_bias[u] + movie_bias[m]) * 4096, 12);
      err = clamp_l(longint'(rating_i) - pred, -32768, 32767);
      r.pred = 16'(clamp_l(pred, -32768, 32767));
      r.err = 16'(err);
      r.sq = 32'(clamp_l(err * err, 0, 64'hFFFF_FFFF));
      if (action_i == ACT_TRAIN) begin
        user_bias[u] = sgd_step(user_bias[u], err * 65536);
        movie_bias[m] = sgd_step(movie_bias[m], err * 65536);
        for (k = 0; k < NF; k++) begin
          p = user_factor[u*NF+k];
          q = movie_factor[m*NF+k];
          // movie side uses the user factor from before this step
          user_factor[u*NF+k] = sgd_step(p, err * q * 16);
          movie_factor[m*NF+k] = sgd_step(q, err * p * 16);
        end
      end
    end
    rating_results_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    rating_result_t exp_r;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_USER_COUNT:  user_count_r  = pwdata[10:0];
          REG_MOVIE_COUNT: movie_count_r = pwdata[11:0];
          REG_LEARN_RATE:  learn_rate_r  = pwdata[15:0];
          REG_DECAY:       decay_r       = pwdata[15:0];
          REG_GLOBAL_MEAN: mean_r        = pwdata[14:0];
          default: ;
        endcase
      end
      if (start && !busy) predict_rating();
      if (result_valid_o) begin
        if (rating_results_q.size() == 0) begin
          fails_o++;
          if (fails_o <= 10) $display("unexpected result pred=%0d err=%0d sq=%0d oor=%0b",
                                      predicted_rating_o, rating_error_o, squared_error_o,
                                      out_of_range_o);
        end else begin
          exp_r = rating_results_q.pop_front();
          if (exp_r.pred !== predicted_rating_o || exp_r.err !== rating_error_o ||
              exp_r.sq !== squared_error_o || exp_r.oor !== out_of_range_o) begin
            fails_o++;
            if (fails_o <= 10)
              $display("mismatch: exp pred=%0d err=%0d sq=%0d oor=%0b, got %0d %0d %0d %0b",
                       exp_r.pred, exp_r.err, exp_r.sq, exp_r.oor, predicted_rating_o,
                       rating_error_o, squared_error_o, out_of_range_o);
          end
        end
      end
    end
    pending_o = rating_results_q.size();
  end

endmodule

/* tb/tb_biased_matrix_factorization_sgd.sv */
module tb_biased_matrix_factorization_sgd;
  import mfs_pkg::*;

  localparam int NF = FACTORS_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = ACT_PREDICT;
  logic [9:0] user_index_i = '0;
  logic [10:0] movie_index_i = '0;
  logic [14:0] rating_i = '0;
  logic [4:0] factor_slot_i = '0;
  logic signed [15:0] factor_value_i = '0;
  logic result_valid_o;
  logic signed [15:0] predicted_rating_o, rating_error_o;
  logic [31:0] squared_error_o;
  logic out_of_range_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int pending, fails;
  int cycles = 0;

  biased_matrix_factorization_sgd u_top (.*);

  mfs_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .action_i, .user_index_i, .movie_index_i, .rating_i,
    .factor_slot_i, .factor_value_i, .result_valid_o, .predicted_rating_o, .rating_error_o,
    .squared_error_o, .out_of_range_o, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .pending_o(pending), .fails_o(fails)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[biased_matrix_factorization_sgd] ERROR");
      $finish;
    end
  end

  // rows that are fully loaded and safe to train on
  int user_pool[5] = '{0, 1, 2, 3, 1023};
  int movie_pool[5] = '{0, 1, 2, 3, 2047};
  logic [NF-1:0] user_loaded[1024];
  logic [NF-1:0] movie_loaded[2048];
  int cur_users = USER_COUNT_RST;
  int cur_movies = MOVIE_COUNT_RST;
  bit gaps_on = 1'b1;

  task automatic issue(logic [1:0] act, int u, int m, int rt, int slot, int fv);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    action_i = act;
    user_index_i = u;
    movie_index_i = m;
    rating_i = rt;
    factor_slot_i = slot;
    factor_value_i = fv;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    if (act == ACT_WR_USER && u < cur_users && slot < NF) user_loaded[u][slot] = 1'b1;
    if (act == ACT_WR_MOVIE && m < cur_movies && slot < NF) movie_loaded[m][slot] = 1'b1;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    // a train keeps updating after its result
    repeat (40) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, int value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(int uc, int mc, int lr, int dc, int gm);
    wait_drained();
    reg_write(REG_USER_COUNT, uc);
    reg_write(REG_MOVIE_COUNT, mc);
    reg_write(REG_LEARN_RATE, lr);
    reg_write(REG_DECAY, dc);
    reg_write(REG_GLOBAL_MEAN, gm);
    cur_users = uc;
    cur_movies = mc;
  endtask

  function automatic int rand_factor();
    if ($urandom_range(0, 1)) return $urandom_range(0, 8191) - 4096;
    return $signed(16'($urandom()));
  endfunction

  function automatic int safe_user(int u);
    if (u < cur_users && user_loaded[u] != '1) return user_pool[0];
    return u;
  endfunction

  function automatic int safe_movie(int m);
    if (m < cur_movies && movie_loaded[m] != '1) return movie_pool[0];
    return m;
  endfunction

  task automatic random_item();
    int r, u, m;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      u = $urandom_range(0, 3) != 0 ? user_pool[$urandom_range(0, 4)] : $urandom_range(0, 1023);
      m = $urandom_range(0, 3) != 0 ? movie_pool[$urandom_range(0, 4)] : $urandom_range(0, 2047);
      issue(r < 45 ? ACT_TRAIN : ACT_PREDICT, safe_user(u), safe_movie(m),
            $urandom_range(0, 20480), $urandom_range(0, 31), rand_factor());
    end else if (r < 85) begin
      issue(ACT_WR_USER, user_pool[$urandom_range(0, 4)], $urandom_range(0, 2047),
            $urandom_range(0, 20480), $urandom_range(0, NF-1), rand_factor());
    end else if (r < 92) begin
      issue(ACT_WR_MOVIE, $urandom_range(0, 1023), movie_pool[$urandom_range(0, 4)],
            $urandom_range(0, 20480), $urandom_range(0, NF-1), rand_factor());
    end else begin
      issue($urandom_range(0, 1) ? ACT_WR_USER : ACT_WR_MOVIE, $urandom_range(0, 1023),
            $urandom_range(0, 2047), $urandom_range(0, 20480), $urandom_range(0, 31),
            rand_factor());
    end
  endtask

  initial begin
    foreach (user_loaded[i]) user_loaded[i] = '0;
    foreach (movie_loaded[i]) movie_loaded[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // load the pool rows
    for (int p = 0; p < 5; p++) begin
      for (int k = 0; k < NF; k++) begin
        issue(ACT_WR_USER, user_pool[p], 0, 0, k, rand_factor());
        issue(ACT_WR_MOVIE, 0, movie_pool[p], 0, k, rand_factor());
      end
    end

    // directed: extremes and rejected writes
    issue(ACT_WR_USER, 1023, 0, 0, 0, -32768);
    issue(ACT_WR_MOVIE, 0, 2047, 0, NF-1, 32767);
    issue(ACT_TRAIN, 1023, 2047, 20480, 0, 0);
    issue(ACT_PREDICT, 1023, 2047, 0, 0, 0);
    issue(ACT_TRAIN, 0, 0, 0, 0, 0);
    issue(ACT_TRAIN, 0, 0, 20480, 0, 0);
    issue(ACT_PREDICT, 1, 1, 14459, 0, 0);
    issue(ACT_WR_USER, 2, 0, 0, NF, 100);
    issue(ACT_WR_MOVIE, 0, 2, 0, 31, -100);
    issue(ACT_WR_USER, 3, 0, 0, 7, 32767);
    issue(ACT_WR_MOVIE, 0, 3, 0, 7, -32768);
    issue(ACT_TRAIN, 3, 3, 20480, 0, 0);
    issue(ACT_TRAIN, 3, 3, 0, 0, 0);

    // pause until the block has drained
    wait_drained();

    set_config(1024, 2048, 65535, 65535, 20480);
    repeat (250) random_item();
    set_config(0, 0, 0, 0, 0);
    issue(ACT_TRAIN, 0, 0, 20480, 0, 0);
    issue(ACT_WR_USER, 0, 0, 0, 0, 5);
    issue(ACT_WR_MOVIE, 0, 0, 0, 0, 5);
    repeat (60) random_item();
    set_config(1, 1, 4000, 100, 8192);
    repeat (200) random_item();
    set_config(600, 1500, $urandom_range(0, 2000), $urandom_range(0, 65535),
               $urandom_range(0, 20480));
    repeat (300) random_item();
    set_config(1024, 2048, 0, 0, 14459);
    repeat (200) random_item();
    set_config(1024, 1, 1, 1, 1);
    repeat (200) random_item();
    set_config(USER_COUNT_RST, MOVIE_COUNT_RST, LEARN_RATE_RST, DECAY_RST, GLOBAL_MEAN_RST);
    repeat (300) random_item();
    gaps_on = 1'b0;
    repeat (250) random_item();

    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fails == 0) begin
      $display("[biased_matrix_factorization_sgd] OK");
    end else begin
      $display("[biased_matrix_factorization_sgd] ERROR");
    end
    $finish;
  end

endmodule
